FILE: sv/lora_air_pkg.sv
// Shared widths, constants, register codes and pipeline types of the LoRa airtime estimator.
package lora_air_pkg;

  localparam int LenW     = 8;
  localparam int SfW      = 4;
  localparam int BwW      = 19;
  localparam int CrW      = 4;
  localparam int PreW     = 16;
  localparam int AirW     = 26;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 19;

  localparam int NumW    = 12;
  localparam int DenW    = 6;
  localparam int BlkQW   = 7;
  localparam int BlkRemW = 6;
  localparam int PsymW   = 10;
  localparam int QW      = 19;
  localparam int ProdW   = 28;
  localparam int DivW    = 38;
  localparam int QuoRemW = BwW;

  localparam int NumBlkCells = BlkQW;
  localparam int NumQuoCells = AirW;

  localparam logic [SfW-1:0]   SfMin      = 4'd6;
  localparam logic [SfW-1:0]   SfMax      = 4'd12;
  localparam logic [SfW-1:0]   LdroSfMin  = 4'd11;
  localparam logic [SfW-1:0]   LdroSfCut  = 4'd2;
  localparam logic [SfW-1:0]   ShiftBias  = 4'd2;
  localparam logic [CrW-1:0]   CrMin      = 4'd5;
  localparam logic [CrW-1:0]   CrMax      = 4'd8;
  localparam logic [BwW-1:0]   BwMin      = 19'd7800;
  localparam logic [BwW-1:0]   BwLdroMax  = 19'd125000;
  localparam logic [NumW-1:0]  PayloadOfs = 12'd44;
  localparam logic [PsymW-1:0] PsymBase   = 10'd8;
  localparam logic [QW-1:0]    QuarterOvh = 19'd17;
  localparam logic [ProdW-1:0] MsPerSec   = 28'd1000;

  localparam logic [SfW-1:0]      SfRst  = 4'd7;
  localparam logic [BwW-1:0]      BwRst  = 19'd125000;
  localparam logic [CrW-1:0]      CrRst  = 4'd5;
  localparam logic [PreW-1:0]     PreRst = 16'd8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSpread    = 4'd0,
    CfgBandwidth = 4'd1,
    CfgCodeRate  = 4'd2,
    CfgPreamble  = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [SfW-1:0]  sf;
    logic [BwW-1:0]  bw;
    logic [CrW-1:0]  cr;
    logic [PreW-1:0] pre;
    logic [DenW-1:0] den;
    logic [SfW-1:0]  shamt;
  } cfg_t;

  typedef struct packed {
    logic [BlkRemW-1:0] rem;
    logic [BlkQW-1:0]   quo;
  } blk_work_t;

  typedef struct packed {
    logic [QuoRemW-1:0] rem;
    logic [AirW-1:0]    quo;
  } quo_work_t;

endpackage

FILE: sv/lora_air_cfg.sv
// Configuration registers with clamping of the radio settings into effective values.
module lora_air_cfg import lora_air_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  logic [SfW-1:0]  sf_q;
  logic [BwW-1:0]  bw_q;
  logic [CrW-1:0]  cr_q;
  logic [PreW-1:0] pre_q;
  logic [SfW-1:0]  sf_eff;
  logic [BwW-1:0]  bw_eff;
  logic [CrW-1:0]  cr_eff;
  logic [SfW-1:0]  sf_de;
  logic            de;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_q  <= SfRst;
      bw_q  <= BwRst;
      cr_q  <= CrRst;
      pre_q <= PreRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgSpread:    sf_q  <= cfg_data_i[SfW-1:0];
        CfgBandwidth: bw_q  <= cfg_data_i[BwW-1:0];
        CfgCodeRate:  cr_q  <= cfg_data_i[CrW-1:0];
        CfgPreamble:  pre_q <= cfg_data_i[PreW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sf_eff = (sf_q < SfMin) ? SfMin : ((sf_q > SfMax) ? SfMax : sf_q);
    bw_eff = (bw_q < BwMin) ? BwMin : bw_q;
    cr_eff = (cr_q < CrMin) ? CrMin : ((cr_q > CrMax) ? CrMax : cr_q);
    de     = (sf_eff >= LdroSfMin) && (bw_eff <= BwLdroMax);
    sf_de  = de ? (sf_eff - LdroSfCut) : sf_eff;

    cfg_o.sf    = sf_eff;
    cfg_o.bw    = bw_eff;
    cfg_o.cr    = cr_eff;
    cfg_o.pre   = pre_q;
    cfg_o.den   = {sf_de, 2'b00};
    cfg_o.shamt = sf_eff - ShiftBias;
  end

endmodule

FILE: sv/lora_air_blk_cell.sv
// One cell of the payload block divider row: one quotient bit per cell.
module lora_air_blk_cell import lora_air_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [DenW-1:0] den_i,
  input  logic            valid_i,
  input  blk_work_t       work_i,
  output logic            ready_o,
  output logic            valid_o,
  output blk_work_t       work_o,
  input  logic            ready_i
);

  logic            valid_q;
  blk_work_t       work_q;
  blk_work_t       work_d;
  logic [BlkRemW:0] trial;
  logic [BlkRemW:0] diff;
  logic            take;

  always_comb begin
    trial = {work_i.rem, work_i.quo[BlkQW-1]};
    diff  = trial - {1'b0, den_i};
    take  = trial >= {1'b0, den_i};
    work_d.rem = take ? diff[BlkRemW-1:0] : trial[BlkRemW-1:0];
    work_d.quo = {work_i.quo[BlkQW-2:0], take};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

FILE: sv/lora_air_quo_cell.sv
// One cell of the airtime divider row: one quotient bit per cell against the bandwidth.
module lora_air_quo_cell import lora_air_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [BwW-1:0] bw_i,
  input  logic           valid_i,
  input  quo_work_t      work_i,
  output logic           ready_o,
  output logic           valid_o,
  output quo_work_t      work_o,
  input  logic           ready_i
);

  logic               valid_q;
  quo_work_t          work_q;
  quo_work_t          work_d;
  logic [QuoRemW:0]   trial;
  logic [QuoRemW:0]   diff;
  logic               take;

  always_comb begin
    trial = {work_i.rem, work_i.quo[AirW-1]};
    diff  = trial - {1'b0, bw_i};
    take  = trial >= {1'b0, bw_i};
    work_d.rem = take ? diff[QuoRemW-1:0] : trial[QuoRemW-1:0];
    work_d.quo = {work_i.quo[AirW-2:0], take};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

FILE: sv/lora_air_ce_top_placeholder_unused.sv
// Airtime pipeline stages between the two divider rows: symbol count, scaling and shift.
module lora_air_mid import lora_air_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  input  logic [BlkQW-1:0] blocks_i,
  output logic             ready_o,
  output logic             valid_o,
  output quo_work_t        work_o,
  input  logic             ready_i
);

  logic                   q_valid_q;
  logic [QW-1:0]          q_q;
  logic                   m_valid_q;
  logic [ProdW-1:0]       prod_q;
  logic                   s_valid_q;
  quo_work_t              s_work_q;
  logic                   q_ready;
  logic                   m_ready;
  logic                   s_ready;
  logic [BlkQW+CrW-1:0]   blk_cr;
  logic [PsymW-1:0]       psym;
  logic [PreW:0]          sym_sum;
  logic [QW-1:0]          q_d;
  logic [DivW-1:0]        dividend;

  always_comb begin
    blk_cr   = (BlkQW+CrW)'(blocks_i) * (BlkQW+CrW)'(cfg_i.cr);
    psym     = blk_cr[PsymW-1:0] + PsymBase;
    sym_sum  = (PreW+1)'(cfg_i.pre) + (PreW+1)'(psym);
    q_d      = {sym_sum, 2'b00} + QuarterOvh;
    dividend = DivW'(prod_q) << cfg_i.shamt;
  end

  assign s_ready = !s_valid_q || ready_i;
  assign m_ready = !m_valid_q || s_ready;
  assign q_ready = !q_valid_q || m_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      if (q_ready) begin
        q_valid_q <= valid_i;
      end
      if (m_ready) begin
        m_valid_q <= q_valid_q;
      end
      if (s_ready) begin
        s_valid_q <= m_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_ready && valid_i) begin
      q_q <= q_d;
    end
    if (m_ready && q_valid_q) begin
      prod_q <= ProdW'(q_q) * MsPerSec;
    end
    if (s_ready && m_valid_q) begin
      s_work_q.rem <= QuoRemW'(dividend[DivW-1:AirW]);
      s_work_q.quo <= dividend[AirW-1:0];
    end
  end

  assign ready_o = q_ready;
  assign valid_o = s_valid_q;
  assign work_o  = s_work_q;

endmodule

FILE: sv/lora_airtime_estimator.sv
// Throughput: one request per cycle while the output is not stalled; each divider row
// settles one quotient bit per cell, 7 cells for the payload block count and 26 cells
// for the airtime in milliseconds. A stall at the output ripples back only through full
// cells, so bubbles are filled. Reset empties the whole pipeline and loads the radio
// settings with their default values.
module lora_airtime_estimator import lora_air_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [LenW-1:0]     payload_len_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [AirW-1:0]     airtime_ms_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t             cfg;
  logic             e_valid_q;
  blk_work_t        e_work_q;
  logic             e_ready;
  logic [NumW-1:0]  pos;
  logic [NumW-1:0]  neg;
  logic [NumW-1:0]  num;
  logic             out_valid_q;
  logic [AirW-1:0]  airtime_q;
  logic             out_ready;
  logic             mid_ready;

  logic      blk_valid [NumBlkCells+1];
  blk_work_t blk_work  [NumBlkCells+1];
  logic      blk_ready [NumBlkCells+1];
  logic      quo_valid [NumQuoCells+1];
  quo_work_t quo_work  [NumQuoCells+1];
  logic      quo_ready [NumQuoCells+1];

  lora_air_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Rounding up is folded in by adding the divisor less one before the division.
  always_comb begin
    pos = {1'b0, payload_len_i, 3'b000} + PayloadOfs;
    neg = NumW'({cfg.sf, 2'b00});
    num = (pos > neg) ? (pos - neg + NumW'(cfg.den) - NumW'(1)) : '0;
  end

  assign e_ready    = !e_valid_q || blk_ready[0];
  assign in_stall_o = !e_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (e_ready) begin
      e_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_ready && in_valid_i) begin
      e_work_q.rem <= BlkRemW'(num[NumW-1:BlkQW]);
      e_work_q.quo <= num[BlkQW-1:0];
    end
  end

  assign blk_valid[0] = e_valid_q;
  assign blk_work[0]  = e_work_q;

  for (genvar i = 0; i < NumBlkCells; i++) begin : g_blk
    lora_air_blk_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .den_i   (cfg.den),
      .valid_i (blk_valid[i]),
      .work_i  (blk_work[i]),
      .ready_o (blk_ready[i]),
      .valid_o (blk_valid[i+1]),
      .work_o  (blk_work[i+1]),
      .ready_i (blk_ready[i+1])
    );
  end

  assign blk_ready[NumBlkCells] = mid_ready;

  lora_air_mid u_mid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (blk_valid[NumBlkCells]),
    .blocks_i (blk_work[NumBlkCells].quo),
    .ready_o  (mid_ready),
    .valid_o  (quo_valid[0]),
    .work_o   (quo_work[0]),
    .ready_i  (quo_ready[0])
  );

  for (genvar j = 0; j < NumQuoCells; j++) begin : g_quo
    lora_air_quo_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bw_i    (cfg.bw),
      .valid_i (quo_valid[j]),
      .work_i  (quo_work[j]),
      .ready_o (quo_ready[j]),
      .valid_o (quo_valid[j+1]),
      .work_o  (quo_work[j+1]),
      .ready_i (quo_ready[j+1])
    );
  end

  assign out_ready              = !out_valid_q || !out_stall_i;
  assign quo_ready[NumQuoCells] = out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= quo_valid[NumQuoCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && quo_valid[NumQuoCells]) begin
      airtime_q <= quo_work[NumQuoCells].quo;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign airtime_ms_o = airtime_q;

`ifndef SYNTHESIS
  a_stall_needs_blocked_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("Input stalled although the output side is free.");

  a_accept_fills_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> e_valid_q)
    else $error("Accepted request did not enter the first stage.");

  a_output_refilled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && quo_valid[NumQuoCells]) |=> out_valid_o)
    else $error("Finished result was dropped at the output register.");
`endif

endmodule

FILE: tb/lora_airtime_checker.sv
// Checker for the LoRa airtime estimator: it predicts the on-air time of every request and compares.
`timescale 1ns / 100ps
module lora_airtime_checker import lora_air_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [LenW-1:0]     payload_len_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [AirW-1:0]     airtime_ms_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         pending_o,
  output int unsigned         mismatch_count_o
);

  logic [SfW-1:0]  spread_q;
  logic [BwW-1:0]  bw_q;
  logic [CrW-1:0]  cr_q;
  logic [PreW-1:0] pre_q;

  logic [AirW-1:0] airtime_due_q[$];
  logic [AirW-1:0] airtime_due;
  int unsigned     mismatch_count = 0;

  assign mismatch_count_o = mismatch_count;

  function automatic logic [AirW-1:0] predict_airtime(input logic [LenW-1:0] len);
    logic [63:0] sf, bw, cr, de, pos, neg, den, blocks, psym, quarters, on_air;
    sf = (spread_q < SfMin) ? 64'(SfMin) : (spread_q > SfMax) ? 64'(SfMax) : 64'(spread_q);
    bw = (bw_q < BwMin) ? 64'(BwMin) : 64'(bw_q);
    cr = (cr_q < CrMin) ? 64'(CrMin) : (cr_q > CrMax) ? 64'(CrMax) : 64'(cr_q);
    de = (sf >= 64'(LdroSfMin) && bw <= 64'(BwLdroMax)) ? 64'd1 : 64'd0;
    pos = 64'(len) * 8 + 64'(PayloadOfs);
    neg = sf * 4;
    den = (sf - 2 * de) * 4;
    blocks = (pos > neg) ? (pos - neg + den - 1) / den : 64'd0;
    psym = 64'(PsymBase) + blocks * cr;
    quarters = (64'(pre_q) + psym) * 4 + 64'(QuarterOvh);
    on_air = quarters * (64'd1 << sf) * 64'(MsPerSec) / (bw * 4);
    return on_air[AirW-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [AirW-1:0] got,
                                 input logic [AirW-1:0] want);
    mismatch_count++;
    $display("%0t ns checker: %s: airtime_ms %0d, predicted %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spread_q  = SfRst;
      bw_q      = BwRst;
      cr_q      = CrRst;
      pre_q     = PreRst;
      airtime_due_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSpread:    spread_q = cfg_data_i[SfW-1:0];
          CfgBandwidth: bw_q     = cfg_data_i[BwW-1:0];
          CfgCodeRate:  cr_q     = cfg_data_i[CrW-1:0];
          CfgPreamble:  pre_q    = cfg_data_i[PreW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        airtime_due_q.push_back(predict_airtime(payload_len_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (airtime_due_q.size() == 0) begin
          report_mismatch("result with no request outstanding", airtime_ms_i, '0);
        end else begin
          airtime_due = airtime_due_q.pop_front();
          if (airtime_ms_i !== airtime_due) begin
            report_mismatch("wrong airtime", airtime_ms_i, airtime_due);
          end
        end
      end
      pending_o <= airtime_due_q.size();
    end
  end

endmodule

FILE: tb/tb_lora_airtime_estimator.sv
// Top-level testbench of the LoRa airtime estimator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_lora_airtime_estimator import lora_air_pkg::*;;

  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned StuckLimit    = 4000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned RandomPhases  = 18;
  localparam int unsigned PhaseRequests = 100;
  localparam logic [CfgIdxW-1:0] CfgFirstUnused = CfgIdxW'(int'(CfgPreamble) + 1);

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [LenW-1:0]     payload_len_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [AirW-1:0]     airtime_ms_o;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  int unsigned pending;
  int unsigned mismatch_count;
  int unsigned quiet_cycles = 0;
  bit          calm_in      = 1'b0;
  bit          calm_out     = 1'b0;
  bit          hold_off     = 1'b0;
  bit          hold_done    = 1'b0;

  lora_airtime_estimator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .payload_len_i (payload_len_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .airtime_ms_o  (airtime_ms_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  lora_airtime_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .payload_len_i    (payload_len_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .airtime_ms_i     (airtime_ms_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .pending_o        (pending),
    .mismatch_count_o (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_request(input logic [LenW-1:0] len);
    int unsigned gap;
    gap = calm_in ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    payload_len_i <= len;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_radio(input logic [CfgDataW-1:0] sf, input logic [CfgDataW-1:0] bw,
                           input logic [CfgDataW-1:0] cr, input logic [CfgDataW-1:0] pre);
    write_reg(CfgSpread, sf);
    write_reg(CfgBandwidth, bw);
    write_reg(CfgCodeRate, cr);
    write_reg(CfgPreamble, pre);
    cfg_we_i <= 1'b0;
  endtask

  // The receiver may stall before each result, never in calm phases; once it holds off for a long stretch.
  initial begin
    int unsigned wait_n;
    forever begin
      if (hold_off && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      wait_n = calm_out ? 0 : $urandom_range(0, 10);
      if (wait_n != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StuckLimit) begin
        $display("watchdog: no request or result moved for %0d cycles", StuckLimit);
        $display("tb_lora_airtime_estimator: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [CfgDataW-1:0] bw_data, pre_data;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default settings straight after reset.
    send_request(8'd0);
    send_request(8'd255);
    send_request(8'h55);
    send_request(8'hAA);
    drain();

    // Spreading factor and coding rate below range, zero bandwidth, zero preamble.
    write_reg(CfgFirstUnused, '1);
    set_radio(19'd0, 19'd0, 19'd0, 19'd0);
    send_request(8'd0);
    send_request(8'd255);
    send_request(8'd3);
    drain();

    // Both above range with the low-data-rate mode on; the payload term goes negative.
    set_radio(19'h7FFFF, 19'd125000, 19'd15, 19'd65535);
    send_request(8'd0);
    send_request(8'd255);
    send_request(8'd1);
    drain();

    // Just past the low-data-rate bandwidth limit, where the payload term is exactly zero.
    set_radio(19'd11, 19'd125001, 19'd8, 19'd8);
    send_request(8'd0);
    send_request(8'd255);
    drain();

    // Bandwidth just below its floor.
    set_radio(19'd11, 19'd7799, 19'd5, 19'd12);
    send_request(8'd0);
    send_request(8'd1);
    send_request(8'd255);
    drain();

    set_radio(19'd12, 19'h7FFFF, 19'd6, 19'hFFFF);
    send_request(8'd255);
    send_request(8'd0);
    drain();

    set_radio(19'd6, 19'd7800, 19'd7, 19'd1);
    send_request(8'd255);
    send_request(8'd0);
    drain();

    for (int p = 0; p < RandomPhases; p++) begin
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      if (p == 2) begin
        calm_in  = 1'b1;
        hold_off = 1'b1;
      end
      case ($urandom_range(0, 5))
        0:       bw_data = CfgDataW'(int'(BwLdroMax) << $urandom_range(0, 2));
        1:       bw_data = CfgDataW'(int'(BwLdroMax) >> $urandom_range(1, 4));
        2:       bw_data = CfgDataW'($urandom_range(0, int'(BwMin) + 16));
        3:       bw_data = CfgDataW'($urandom_range(int'(BwLdroMax) - 8, int'(BwLdroMax) + 8));
        default: bw_data = CfgDataW'($urandom());
      endcase
      case ($urandom_range(0, 4))
        3:       pre_data = CfgDataW'($urandom()) | CfgDataW'(16'hFFFF);
        4:       pre_data = CfgDataW'($urandom());
        default: pre_data = CfgDataW'($urandom_range(0, 32));
      endcase
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CfgIdxW'($urandom_range(int'(CfgFirstUnused), (1 << CfgIdxW) - 1)),
                  CfgDataW'($urandom()));
      end
      set_radio(CfgDataW'($urandom()), bw_data, CfgDataW'($urandom()), pre_data);
      repeat (PhaseRequests) send_request(LenW'($urandom()));
      drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_lora_airtime_estimator: done, clean");
    end else begin
      $display("tb_lora_airtime_estimator: done, errors");
    end
    $finish;
  end

endmodule
